/* rtl/ax25_pkg.sv */
`timescale 1ns / 1ps
package ax25_pkg;

  localparam int MAX_REPEATERS = 2;
  localparam int MIN_FRAME     = 7 + 7 + 2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;

  // record kinds on out_tuser
  localparam logic [1:0] REC_ADDR    = 2'd0;
  localparam logic [1:0] REC_HEADER  = 2'd1;
  localparam logic [1:0] REC_PAYLOAD = 2'd2;
  localparam logic [1:0] REC_STATUS  = 2'd3;

  localparam logic [1:0] ROLE_DEST     = 2'd0;
  localparam logic [1:0] ROLE_SOURCE   = 2'd1;
  localparam logic [1:0] ROLE_REPEATER = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
  localparam logic [2:0] ST_DEST_ONLY    = 3'd2;
  localparam logic [2:0] ST_RPT_TRUNC    = 3'd3;
  localparam logic [2:0] ST_TOO_MANY_RPT = 3'd4;
  localparam logic [2:0] ST_HDR_TRUNC    = 3'd5;
  localparam logic [2:0] ST_NOT_UI       = 3'd6;

  localparam logic [1:0] PH_ADDR    = 2'd0;
  localparam logic [1:0] PH_CTRL    = 2'd1;
  localparam logic [1:0] PH_PROTO   = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [7:0] CTRL_UI        = 8'h03;
  localparam logic [6:0] CHAR_SPACE     = 7'h20;
  localparam logic [7:0] PROTO_NO_L3    = 8'hF0;

  // last field in the lowest bits
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [7:0]  protocol_value;
    logic [7:0]  control_value;
    logic        command_response;
    logic [3:0]  ssid;
    logic [2:0]  callsign_length;
    logic [41:0] callsign;
    logic [2:0]  repeater_index;
    logic [1:0]  address_role;
  } rec_data_t;

  typedef struct packed {
    logic [1:0] record_type;
    rec_data_t  data;
    logic       last;
  } rec_t;

endpackage

/* rtl/ax25_ui_header_parser.sv */
`timescale 1ns / 1ps
// AX.25 UI header parser. Takes one frame byte per cycle (checksum removed,
// last byte marked by in_tlast) and emits address, header, payload and status
// records. Each byte's decode is a single registered pass and its records go
// into a four-word result queue; a byte is taken whenever the queue has room
// for two words, so throughput is one byte per cycle as long as the consumer
// takes one word per cycle, with the closing byte of a frame producing two
// words. A byte's records are queued as it is taken. expected_protocol is to
// be written through cfg_we/cfg_wdata only while idle, which is not enforced.
module ax25_ui_header_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [7:0]                      cfg_wdata,   // expected_protocol
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ax25_pkg::IN_DATA_W-1:0]  in_tdata,    // data_byte
  input  logic                            in_tlast,    // end_of_frame
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // address_role, repeater_index, callsign, callsign_length, ssid,
  // command_response, control_value, protocol_value, payload_byte, status, pad
  output logic [ax25_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [ax25_pkg::OUT_USER_W-1:0] out_tuser,   // record_type
  output logic                            out_tlast    // last
);
  import ax25_pkg::*;

  logic [7:0]  exp_proto_r;
  logic [4:0]  byte_cnt_r, byte_cnt_nxt;
  logic [2:0]  addr_pos_r, addr_pos_nxt;
  logic [3:0]  addr_num_r, addr_num_nxt;
  logic [41:0] call_r, call_nxt;
  logic [2:0]  chars_r, chars_nxt;
  logic        space_r, space_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;

  rec_t        q_r [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  cnt_r, cnt_nxt;

  rec_t        rec0, rec_st;
  logic        rec0_v;
  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic [6:0]  ch;
  logic        more;
  logic [1:0]  n_push;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign b       = in_tdata;
  assign ch      = b[7:1];
  assign more    = ~b[0];

  always_comb begin
    byte_cnt_nxt = (byte_cnt_r == 5'd31) ? byte_cnt_r : byte_cnt_r + 5'd1;
    addr_pos_nxt = addr_pos_r;
    addr_num_nxt = addr_num_r;
    call_nxt     = call_r;
    chars_nxt    = chars_r;
    space_nxt    = space_r;
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    ctrl_nxt     = ctrl_r;
    rec0         = '0;
    rec0_v       = 1'b0;
    rec_st       = '0;

    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_ADDR: begin
          if (addr_pos_r < 3'd6) begin
            if (space_r || ch == CHAR_SPACE) begin
              space_nxt = 1'b1;
            end else if (chars_r < 3'd6) begin
              for (int k = 0; k < 6; k++) begin
                if (chars_r == 3'(k)) begin
                  call_nxt[41-7*k -: 7] = call_r[41-7*k -: 7] | ch;
                end
              end
              chars_nxt = chars_r + 3'd1;
            end
            addr_pos_nxt = addr_pos_r + 3'd1;
          end else begin
            rec0_v                       = 1'b1;
            rec0.record_type             = REC_ADDR;
            rec0.data.address_role       = (addr_num_r == 4'd0) ? ROLE_DEST :
                                           (addr_num_r == 4'd1) ? ROLE_SOURCE :
                                           ROLE_REPEATER;
            rec0.data.repeater_index     = (addr_num_r >= 4'd2) ?
                                           3'(addr_num_r - 4'd2) : 3'd0;
            rec0.data.callsign           = call_r;
            rec0.data.callsign_length    = chars_r;
            rec0.data.ssid               = b[4:1];
            rec0.data.command_response   = b[7];
            addr_pos_nxt = '0;
            call_nxt     = '0;
            chars_nxt    = '0;
            space_nxt    = 1'b0;
            if (addr_num_r == 4'd0) begin
              if (!more) err_nxt = ST_DEST_ONLY;
            end else if (!more) begin
              phase_nxt = PH_CTRL;
            end else if (addr_num_r - 4'd1 >= 4'(MAX_REPEATERS)) begin
              err_nxt = ST_TOO_MANY_RPT;
            end
            if (addr_num_r != 4'd15) addr_num_nxt = addr_num_r + 4'd1;
          end
        end
        PH_CTRL: begin
          ctrl_nxt  = b;
          phase_nxt = PH_PROTO;
        end
        PH_PROTO: begin
          rec0_v                   = 1'b1;
          rec0.record_type         = REC_HEADER;
          rec0.data.control_value  = ctrl_r;
          rec0.data.protocol_value = b;
          if (ctrl_r == CTRL_UI && b == exp_proto_r) phase_nxt = PH_PAYLOAD;
          else err_nxt = ST_NOT_UI;
        end
        PH_PAYLOAD: begin
          rec0_v                 = 1'b1;
          rec0.record_type       = REC_PAYLOAD;
          rec0.data.payload_byte = b;
        end
        default: ;
      endcase
    end

    rec_st.record_type = REC_STATUS;
    rec_st.last        = 1'b1;
    priority if (byte_cnt_nxt < 5'(MIN_FRAME)) rec_st.data.status = ST_TOO_SHORT;
    else if (err_nxt != ST_OK)                 rec_st.data.status = err_nxt;
    else if (phase_nxt == PH_ADDR)             rec_st.data.status = ST_RPT_TRUNC;
    else if (phase_nxt != PH_PAYLOAD)          rec_st.data.status = ST_HDR_TRUNC;
    else                                       rec_st.data.status = ST_OK;

    // frame end: return per-frame state to reset
    if (in_tlast) begin
      byte_cnt_nxt = '0;
      addr_pos_nxt = '0;
      addr_num_nxt = '0;
      call_nxt     = '0;
      chars_nxt    = '0;
      space_nxt    = 1'b0;
      phase_nxt    = PH_ADDR;
      err_nxt      = ST_OK;
      ctrl_nxt     = '0;
    end
  end

  assign n_push  = in_acc ? (2'(rec0_v) + 2'(in_tlast)) : 2'd0;
  assign cnt_nxt = cnt_r + 3'(n_push) - 3'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_proto_r <= PROTO_NO_L3;
      byte_cnt_r  <= '0;
      addr_pos_r  <= '0;
      addr_num_r  <= '0;
      call_r      <= '0;
      chars_r     <= '0;
      space_r     <= 1'b0;
      phase_r     <= PH_ADDR;
      err_r       <= ST_OK;
      ctrl_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) exp_proto_r <= cfg_wdata;
      if (in_acc) begin
        byte_cnt_r <= byte_cnt_nxt;
        addr_pos_r <= addr_pos_nxt;
        addr_num_r <= addr_num_nxt;
        call_r     <= call_nxt;
        chars_r    <= chars_nxt;
        space_r    <= space_nxt;
        phase_r    <= phase_nxt;
        err_r      <= err_nxt;
        ctrl_r     <= ctrl_nxt;
      end
      wr_ptr_r <= wr_ptr_r + n_push;
      rd_ptr_r <= rd_ptr_r + 2'(out_acc);
      cnt_r    <= cnt_nxt;
    end
  end

  // queue words: the byte's own record first, then the status word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (rec0_v) begin
        q_r[wr_ptr_r] <= rec0;
        if (in_tlast) q_r[wr_ptr_r + 2'd1] <= rec_st;
      end else if (in_tlast) begin
        q_r[wr_ptr_r] <= rec_st;
      end
    end
  end

  assign in_tready  = (cnt_r <= 3'd2);
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {6'd0, q_r[rd_ptr_r].data};
  assign out_tuser  = q_r[rd_ptr_r].record_type;
  assign out_tlast  = q_r[rd_ptr_r].last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_eof_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> cnt_r != 3'd0)
    else $error("frame end left no status word");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == REC_STATUS)
    else $error("last flag on a non-status record");
`endif

endmodule
